/* rtl/ttlat_pkg.sv */
// ----------------------------------------------------------------------------
// ttlat_pkg
// Types, constants and helper functions of the TTL anomaly tracker.
// ----------------------------------------------------------------------------
package ttlat_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam int ADDR_W   = 32;
   localparam int TTL_W    = 8;
   localparam int PKTS_W   = 32;
   localparam int TOTAL_W  = 32;
   localparam int USED_W   = 7;
   localparam int STATUS_W = 2;

   localparam logic [TTL_W-1:0] BASE_LOW       = 8'd64;
   localparam logic [TTL_W-1:0] BASE_MID       = 8'd128;
   localparam logic [TTL_W-1:0] BASE_HIGH      = 8'd255;
   localparam logic [TTL_W-1:0] THRESHOLD_INIT = 8'd20;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NORMAL   = 2'd0,
      STATUS_ANOMALY  = 2'd1,
      STATUS_REJECTED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

   // lookup answer of one cell, all zero when the cell does not match
   typedef struct packed {
      logic              hit;
      logic [TTL_W-1:0]  baseline;
      logic [PKTS_W-1:0] packets;
      logic              flag;
   } hit_type;

   // write command broadcast to the row
   typedef struct packed {
      logic              en;
      logic              found;
      logic [ADDR_W-1:0] address;
      logic [TTL_W-1:0]  baseline;
      logic [PKTS_W-1:0] packets;
      logic              flag;
   } write_type;

   function automatic logic [TTL_W-1:0] pick_baseline(input logic [TTL_W-1:0] ttl);
      logic [TTL_W-1:0] base;
      if (ttl <= BASE_LOW) begin
         base = BASE_LOW;
      end else if (ttl <= BASE_MID) begin
         base = BASE_MID;
      end else begin
         base = BASE_HIGH;
      end
      return base;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

endpackage

/* rtl/ttlat_if.sv */
// ----------------------------------------------------------------------------
// ttlat_req_if / ttlat_rsp_if
// Valid/ready channels carrying packet beats in and result beats out.
// ----------------------------------------------------------------------------
interface ttlat_req_if
   import ttlat_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] source_address;
   logic [TTL_W-1:0]  hop_limit;

   modport source (output valid, output source_address, output hop_limit, input ready);
   modport sink   (input valid, input source_address, input hop_limit, output ready);
endinterface

interface ttlat_rsp_if
   import ttlat_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                new_source;
   logic                newly_flagged;
   logic [TTL_W-1:0]    baseline;
   logic [PKTS_W-1:0]   source_packets;
   logic [TOTAL_W-1:0]  total_anomalies;
   logic [USED_W-1:0]   entries_used;

   modport source (output valid, output status, output new_source, output newly_flagged,
                   output baseline, output source_packets, output total_anomalies,
                   output entries_used, input ready);
   modport sink   (input valid, input status, input new_source, input newly_flagged,
                   input baseline, input source_packets, input total_anomalies,
                   input entries_used, output ready);
endinterface

/* rtl/ttlat_cell.sv */
// ----------------------------------------------------------------------------
// ttlat_cell
// One table entry: stored key, baseline, packet count and flag, its own key
// comparator and the occupancy handoff to the next cell of the row.
// ----------------------------------------------------------------------------
module ttlat_cell
   import ttlat_pkg::*;
(
   input  logic              clock,
   input  logic [IDX_W-1:0]  cell_index,
   input  logic [CNT_W-1:0]  used_count,
   input  logic              left_used,
   output logic              own_used,
   input  logic [ADDR_W-1:0] key,
   input  logic              capture,
   input  write_type         wr,
   output hit_type           hit_out
);

   logic [ADDR_W-1:0] address_ff;
   logic [TTL_W-1:0]  baseline_ff;
   logic [PKTS_W-1:0] packets_ff;
   logic              flag_ff;
   logic              hit_ff;
   logic              hit_in;
   logic              is_tail;
   logic              wr_sel;

   assign own_used = CNT_W'(cell_index) < used_count;
   // first free cell: left neighbor occupied, this one not
   assign is_tail  = left_used && !own_used;
   assign hit_in   = own_used && (address_ff == key);
   assign wr_sel   = wr.en && (wr.found ? hit_ff : is_tail);

   always_comb begin
      hit_out = '0;
      if (hit_in) begin
         hit_out.hit      = 1'b1;
         hit_out.baseline = baseline_ff;
         hit_out.packets  = packets_ff;
         hit_out.flag     = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         hit_ff <= hit_in;
      end
      if (wr_sel) begin
         address_ff  <= wr.address;
         baseline_ff <= wr.baseline;
         packets_ff  <= wr.packets;
         flag_ff     <= wr.flag;
      end
   end

endmodule

/* rtl/ttlat_merge.sv */
// ----------------------------------------------------------------------------
// ttlat_merge
// Combine the lookup answers of the cell row. Keys are unique, so at most
// one cell answers and an OR over the row selects it.
// ----------------------------------------------------------------------------
module ttlat_merge
   import ttlat_pkg::*;
(
   input  hit_type cell_hits [TABLE_ENTRIES],
   output hit_type merged
);

   always_comb begin
      merged = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         merged = hit_type'(merged | cell_hits[i]);
      end
   end

endmodule

/* rtl/ttl_anomaly_tracker.sv */
// ----------------------------------------------------------------------------
// ttl_anomaly_tracker
// Per-source TTL tracking with anomaly flagging over a row of table cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one packet beat (source address, TTL); rsp_chan returns
//   exactly one result beat per packet, in order. csr_write_enable with
//   csr_write_data sets the anomaly threshold; write it only while idle.
// Timing:
//   An accepted packet is compared against all cells in the match step, and
//   its result is registered in the update step, which waits while the result
//   register is full. The next packet is accepted in the same cycle that the
//   previous result is registered, so packets pass one at a time through the
//   two steps (match over the cell row, then update of the selected cell).
// Reset:
//   Synchronous. The table becomes empty, both counters clear and the
//   threshold returns to 20. No clearing pass: cells beyond the fill count
//   are never compared.
// Backpressure:
//   The result register holds while rsp_chan.ready is low; one more packet
//   may be accepted and matched, then the update waits for the register.
// ----------------------------------------------------------------------------
module ttl_anomaly_tracker
   import ttlat_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ttlat_req_if.sink         req_chan,
   ttlat_rsp_if.source       rsp_chan,
   input  logic              csr_write_enable,
   input  logic [TTL_W-1:0]  csr_write_data
);

   state_type          state_ff, state_in;
   logic [TTL_W-1:0]   threshold_ff;
   logic [CNT_W-1:0]   used_count_ff, used_count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [ADDR_W-1:0]  key_ff;
   logic [TTL_W-1:0]   ttl_ff;
   hit_type            found_ff;
   hit_type            merged;
   hit_type            cell_hits [TABLE_ENTRIES];
   logic               used_chain [TABLE_ENTRIES+1];
   write_type          wr;

   logic               req_fire;
   logic               out_free;
   logic               upd_fire;
   logic               full;
   logic               rejected;
   logic [TTL_W-1:0]   cur_base;
   logic [PKTS_W-1:0]  new_pkts;
   logic               anomaly;
   logic               rising;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_new_ff;
   logic                rsp_rising_ff;
   logic [TTL_W-1:0]    rsp_base_ff;
   logic [PKTS_W-1:0]   rsp_pkts_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;
   logic [USED_W-1:0]   rsp_used_ff;

   // ---------------- control ----------------
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign upd_fire = (state_ff == ST_UPDATE) && out_free;
   assign req_chan.ready = (state_ff == ST_IDLE) || upd_fire;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_fire) state_in = req_fire ? ST_MATCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_INIT;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         key_ff <= req_chan.source_address;
         ttl_ff <= req_chan.hop_limit;
      end
      if (state_ff == ST_MATCH) begin
         found_ff <= merged;
      end
   end

   // ---------------- cell row ----------------
   assign used_chain[0] = 1'b1;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      ttlat_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .used_count (used_count_ff),
         .left_used  (used_chain[i]),
         .own_used   (used_chain[i+1]),
         .key        (key_ff),
         .capture    (state_ff == ST_MATCH),
         .wr         (wr),
         .hit_out    (cell_hits[i])
      );
   end

   ttlat_merge u_merge (
      .cell_hits (cell_hits),
      .merged    (merged)
   );

   // ---------------- update ----------------
   assign full     = used_count_ff == CNT_W'(TABLE_ENTRIES);
   assign rejected = !found_ff.hit && full;
   assign cur_base = found_ff.hit ? found_ff.baseline : pick_baseline(ttl_ff);
   assign new_pkts = sat_inc(found_ff.hit ? found_ff.packets : '0);
   // baseline - ttl > threshold, taken without a signed difference
   assign anomaly  = ({1'b0, ttl_ff} + {1'b0, threshold_ff}) < {1'b0, cur_base};
   assign rising   = anomaly && !(found_ff.hit && found_ff.flag);

   always_comb begin
      wr.en       = upd_fire && !rejected;
      wr.found    = found_ff.hit;
      wr.address  = key_ff;
      wr.baseline = cur_base;
      wr.packets  = new_pkts;
      wr.flag     = anomaly;
   end

   always_comb begin
      used_count_in = used_count_ff;
      total_in      = total_ff;
      if (upd_fire && !rejected) begin
         if (!found_ff.hit) used_count_in = used_count_ff + CNT_W'(1);
         if (rising) total_in = sat_inc(total_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff <= '0;
         total_ff      <= '0;
      end else begin
         used_count_ff <= used_count_in;
         total_ff      <= total_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_fire) begin
         rsp_total_ff <= total_in;
         rsp_used_ff  <= USED_W'(used_count_in);
         if (rejected) begin
            rsp_status_ff <= STATUS_REJECTED;
            rsp_new_ff    <= 1'b0;
            rsp_rising_ff <= 1'b0;
            rsp_base_ff   <= '0;
            rsp_pkts_ff   <= '0;
         end else begin
            rsp_status_ff <= anomaly ? STATUS_ANOMALY : STATUS_NORMAL;
            rsp_new_ff    <= !found_ff.hit;
            rsp_rising_ff <= rising;
            rsp_base_ff   <= cur_base;
            rsp_pkts_ff   <= new_pkts;
         end
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.new_source      = rsp_new_ff;
   assign rsp_chan.newly_flagged   = rsp_rising_ff;
   assign rsp_chan.baseline        = rsp_base_ff;
   assign rsp_chan.source_packets  = rsp_pkts_ff;
   assign rsp_chan.total_anomalies = rsp_total_ff;
   assign rsp_chan.entries_used    = rsp_used_ff;

endmodule

/* rtl/ttlat_checker.sv */
// ----------------------------------------------------------------------------
// ttlat_checker
// Port-level checks of the tracker's result beats, bound to the top level.
// ----------------------------------------------------------------------------
module ttlat_checker
   import ttlat_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_new_source,
   input logic                rsp_newly_flagged,
   input logic [TTL_W-1:0]    rsp_baseline,
   input logic [PKTS_W-1:0]   rsp_source_packets,
   input logic [USED_W-1:0]   rsp_entries_used
);

   // a pending result beat stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // rejection only with a full table and empty entry fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_REJECTED) |->
         (rsp_entries_used == USED_W'(TABLE_ENTRIES)) && !rsp_new_source &&
         !rsp_newly_flagged && (rsp_baseline == '0) && (rsp_source_packets == '0))
      else $error("rejected beat with inconsistent fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_newly_flagged |-> rsp_status == STATUS_ANOMALY)
      else $error("flag rise without anomaly");

   // a fresh entry has seen exactly this packet
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_source |->
         (rsp_source_packets == 32'd1) && (rsp_entries_used != '0))
      else $error("new source with wrong packet count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_REJECTED) |->
         (rsp_baseline == BASE_LOW) || (rsp_baseline == BASE_MID) ||
         (rsp_baseline == BASE_HIGH))
      else $error("baseline outside the allowed set");

endmodule

bind ttl_anomaly_tracker ttlat_checker u_ttlat_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_status         (rsp_chan.status),
   .rsp_new_source     (rsp_chan.new_source),
   .rsp_newly_flagged  (rsp_chan.newly_flagged),
   .rsp_baseline       (rsp_chan.baseline),
   .rsp_source_packets (rsp_chan.source_packets),
   .rsp_entries_used   (rsp_chan.entries_used)
);
